### rtl/core/alpfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpfe_pkg
// Shared types and constants of the addressable LED PWM frame encoder.
// ----------------------------------------------------------------------------
package alpfe_pkg;

  localparam int unsigned LED_COUNT_DEF = 8;
  localparam int unsigned COLOR_W       = 24;
  localparam int unsigned CODE_W        = 8;
  localparam int unsigned INDEX_W       = 8;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned BITPOS_W      = 5;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [BITPOS_W-1:0] LAST_BIT      = BITPOS_W'(COLOR_W - 1);
  localparam logic [CODE_W-1:0]   ONE_CODE_RST  = 8'd148;
  localparam logic [CODE_W-1:0]   ZERO_CODE_RST = 8'd64;

  localparam logic [OP_W-1:0] OP_SET    = 2'd0;
  localparam logic [OP_W-1:0] OP_TOGGLE = 2'd1;
  localparam logic [OP_W-1:0] OP_START  = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ONE_CODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CODE = 1'd1;

  typedef struct packed {
    logic               set;
    logic               toggle;
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] color;
    logic               blank;
  } store_cmd_t;

  typedef struct packed {
    logic              accepted;
    logic              code_valid;
    logic [CODE_W-1:0] duty_code;
    logic              frame_last;
  } result_t;

endpackage

### rtl/core/alpfe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpfe_in_if / alpfe_out_if
// Valid/ready channels for operations into the encoder and results out of it.
// ----------------------------------------------------------------------------
interface alpfe_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [alpfe_pkg::OP_W-1:0]           operation;
  logic [alpfe_pkg::INDEX_W-1:0]        led_index;
  logic [alpfe_pkg::COLOR_W-1:0]        color;
  logic                                 blank;

  modport source (output valid, operation, led_index, color, blank, input ready);
  modport sink   (input valid, operation, led_index, color, blank, output ready);
endinterface

interface alpfe_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 accepted;
  logic                                 code_valid;
  logic [alpfe_pkg::CODE_W-1:0]         duty_code;
  logic                                 frame_last;

  modport source (output valid, accepted, code_valid, duty_code, frame_last, input ready);
  modport sink   (input valid, accepted, code_valid, duty_code, frame_last, output ready);
endinterface

### rtl/core/addressable_led_pwm_frame_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressable_led_pwm_frame_encoder_core
// Keeps per-LED colors and turns a frame into a stream of PWM compare codes.
//
// in_ch carries one operation per transaction: set color, toggle blank,
// start frame or tick. out_ch returns exactly one result per operation:
// accepted, code_valid, duty_code and frame_last. A frame is a leading zero
// code, 24 codes per LED (LED 0 first, color msb first) and a trailing zero
// code flagged frame_last.
// A result appears in the output register the cycle after its operation is
// taken. Throughput is one operation per cycle unless out_ch stalls; the
// color memory is read one tick ahead so back-to-back ticks never wait.
// in_ch.ready is low in reset and otherwise high whenever the output
// register is empty or being drained, so a stall on out_ch holds one result
// and then backs up in_ch. The cfg port writes one_code (index 0) and
// zero_code (index 1); the user must do so only while idle, which the block
// does not enforce. Reset clears the frame state, all colors and blank flags
// to zero and restores the codes to 148 and 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
module addressable_led_pwm_frame_encoder_core #(
  parameter int unsigned LED_COUNT = alpfe_pkg::LED_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  alpfe_in_if.sink                             in_ch,
  alpfe_out_if.source                          out_ch,
  input  logic                                 cfg_wr_en,
  input  logic [alpfe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [alpfe_pkg::CODE_W-1:0]         cfg_wdata
);

  localparam int unsigned IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  logic [alpfe_pkg::CODE_W-1:0]  one_code_r, zero_code_r;
  logic                          out_valid_r;
  alpfe_pkg::result_t            res_r;
  alpfe_pkg::result_t            res_nxt;
  alpfe_pkg::store_cmd_t         store_cmd;
  logic                          accept;
  logic [IDX_W-1:0]              rd_addr;
  logic [alpfe_pkg::COLOR_W-1:0] rd_color;
  logic                          rd_blank;

  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_code_r  <= alpfe_pkg::ONE_CODE_RST;
      zero_code_r <= alpfe_pkg::ZERO_CODE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        alpfe_pkg::CFG_ONE_CODE:  one_code_r  <= cfg_wdata;
        alpfe_pkg::CFG_ZERO_CODE: zero_code_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  alpfe_ctrl #(
    .LED_COUNT (LED_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_ch.operation),
    .led_index (in_ch.led_index),
    .color     (in_ch.color),
    .blank     (in_ch.blank),
    .one_code  (one_code_r),
    .zero_code (zero_code_r),
    .rd_color  (rd_color),
    .rd_blank  (rd_blank),
    .rd_addr   (rd_addr),
    .store_cmd (store_cmd),
    .result    (res_nxt)
  );

  alpfe_store #(
    .LED_COUNT (LED_COUNT)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (store_cmd),
    .rd_addr  (rd_addr),
    .rd_color (rd_color),
    .rd_blank (rd_blank)
  );

  // output register, loaded on every taken transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.accepted   = res_r.accepted;
  assign out_ch.code_valid = res_r.code_valid;
  assign out_ch.duty_code  = res_r.duty_code;
  assign out_ch.frame_last = res_r.frame_last;

endmodule

### rtl/core/alpfe_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpfe_store
// Per-LED color memory with per-entry valid bits and a blank flag vector.
// Read data is registered and follows the address in the next cycle.
// ----------------------------------------------------------------------------
module alpfe_store #(
  parameter int unsigned LED_COUNT = alpfe_pkg::LED_COUNT_DEF,
  localparam int unsigned IDX_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  alpfe_pkg::store_cmd_t             cmd,
  input  logic [IDX_W-1:0]                  rd_addr,
  output logic [alpfe_pkg::COLOR_W-1:0]     rd_color,
  output logic                              rd_blank
);

  logic [alpfe_pkg::COLOR_W-1:0] color_mem [LED_COUNT];
  logic [LED_COUNT-1:0]          valid_r;
  logic [LED_COUNT-1:0]          blank_r;
  logic [alpfe_pkg::COLOR_W-1:0] rd_color_r;
  logic                          rd_valid_r;
  logic                          rd_blank_r;
  logic [IDX_W-1:0]              wr_addr;

  assign wr_addr = cmd.index[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.set) begin
      color_mem[wr_addr] <= cmd.color;
    end
    rd_color_r <= color_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      blank_r    <= '0;
      rd_valid_r <= 1'b0;
      rd_blank_r <= 1'b0;
    end else begin
      if (cmd.set) begin
        valid_r[wr_addr] <= 1'b1;
        blank_r[wr_addr] <= cmd.blank;
      end else if (cmd.toggle) begin
        blank_r[wr_addr] <= ~blank_r[wr_addr];
      end
      rd_valid_r <= valid_r[rd_addr];
      rd_blank_r <= blank_r[rd_addr];
    end
  end

  // entries never written read as zero color
  assign rd_color = rd_valid_r ? rd_color_r : '0;
  assign rd_blank = rd_blank_r;

endmodule

### rtl/core/alpfe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpfe_ctrl
// Frame sequencer: decodes one operation per transaction, advances the
// frame position and forms the result.
// ----------------------------------------------------------------------------
module alpfe_ctrl #(
  parameter int unsigned LED_COUNT = alpfe_pkg::LED_COUNT_DEF,
  localparam int unsigned IDX_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [alpfe_pkg::OP_W-1:0]        operation,
  input  logic [alpfe_pkg::INDEX_W-1:0]     led_index,
  input  logic [alpfe_pkg::COLOR_W-1:0]     color,
  input  logic                              blank,
  input  logic [alpfe_pkg::CODE_W-1:0]      one_code,
  input  logic [alpfe_pkg::CODE_W-1:0]      zero_code,
  input  logic [alpfe_pkg::COLOR_W-1:0]     rd_color,
  input  logic                              rd_blank,
  output logic [IDX_W-1:0]                  rd_addr,
  output alpfe_pkg::store_cmd_t             store_cmd,
  output alpfe_pkg::result_t                result
);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DATA,
    PH_TRAIL
  } phase_t;

  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(LED_COUNT - 1);

  phase_t                          phase_r, phase_nxt;
  logic                            active_r, active_nxt;
  logic [IDX_W-1:0]                pos_r, pos_nxt;
  logic [alpfe_pkg::BITPOS_W-1:0]  bit_r, bit_nxt;
  logic                            in_range;
  logic [alpfe_pkg::COLOR_W-1:0]   shifted;

  assign in_range = ({1'b0, led_index} < (alpfe_pkg::INDEX_W + 1)'(LED_COUNT));
  assign shifted  = rd_color << bit_r;

  always_comb begin
    phase_nxt  = phase_r;
    active_nxt = active_r;
    pos_nxt    = pos_r;
    bit_nxt    = bit_r;
    store_cmd  = '0;
    result     = '0;
    store_cmd.index = led_index;
    store_cmd.color = color;
    store_cmd.blank = blank;
    if (accept) begin
      case (operation)
        alpfe_pkg::OP_SET, alpfe_pkg::OP_TOGGLE: begin
          if (!active_r && in_range) begin
            result.accepted  = 1'b1;
            store_cmd.set    = (operation == alpfe_pkg::OP_SET);
            store_cmd.toggle = (operation == alpfe_pkg::OP_TOGGLE);
          end
        end
        alpfe_pkg::OP_START: begin
          if (!active_r) begin
            result.accepted = 1'b1;
            active_nxt      = 1'b1;
            phase_nxt       = PH_LEAD;
            pos_nxt         = '0;
            bit_nxt         = '0;
          end
        end
        default: begin
          // tick
          if (active_r) begin
            result.accepted   = 1'b1;
            result.code_valid = 1'b1;
            case (phase_r)
              PH_LEAD: begin
                phase_nxt = PH_DATA;
                pos_nxt   = '0;
                bit_nxt   = '0;
              end
              PH_DATA: begin
                result.duty_code = (!rd_blank && shifted[alpfe_pkg::COLOR_W-1])
                                   ? one_code : zero_code;
                if (bit_r == alpfe_pkg::LAST_BIT) begin
                  bit_nxt = '0;
                  if (pos_r == LAST_POS) begin
                    pos_nxt   = '0;
                    phase_nxt = PH_TRAIL;
                  end else begin
                    pos_nxt = pos_r + IDX_W'(1);
                  end
                end else begin
                  bit_nxt = bit_r + alpfe_pkg::BITPOS_W'(1);
                end
              end
              default: begin
                result.frame_last = 1'b1;
                active_nxt        = 1'b0;
                phase_nxt         = PH_LEAD;
                pos_nxt           = '0;
                bit_nxt           = '0;
              end
            endcase
          end
        end
      endcase
    end
  end

  // prefetch the color of the LED that the next tick will send
  assign rd_addr = pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      active_r <= 1'b0;
      pos_r    <= '0;
      bit_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      bit_r    <= bit_nxt;
    end
  end

endmodule
